### src/markov_successor_predictor_defines.svh
// Assertion macros shared by the predictor RTL.
// Depends on nothing; files that assert take it in by `include.
`ifndef MARKOV_SUCCESSOR_PREDICTOR_DEFINES_SVH
`define MARKOV_SUCCESSOR_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk once rst_n is released.
`define MSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge of clk, during reset as well.
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSP_ASSERT(lbl, prop, msg)
`define MSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/msp_pkg.sv
// Shared sizes, status codes and transfer payload types for the predictor.
// Depends on nothing; used by msp_seq and the top level through scoped names.
package msp_pkg;

    localparam int CTX_ENTRIES  = 64;
    localparam int SUCC_PER_CTX = 8;
    localparam int COUNT_BITS   = 32;

    localparam int SYM_W   = 64;
    localparam int CTX_AW  = (CTX_ENTRIES > 1) ? $clog2(CTX_ENTRIES) : 1;
    localparam int CTX_W   = $clog2(CTX_ENTRIES + 1);
    localparam int SAW     = (SUCC_PER_CTX > 1) ? $clog2(SUCC_PER_CTX) : 1;
    localparam int FILL_W  = $clog2(SUCC_PER_CTX + 1);
    localparam int TRANS_W = $clog2(CTX_ENTRIES * SUCC_PER_CTX + 1);
    localparam int OBS_W   = 32;

    localparam int SUCC_AW    = CTX_AW + SAW;
    localparam int SUCC_DEPTH = CTX_ENTRIES * (2 ** SAW);
    localparam int CTX_WORD   = SYM_W + FILL_W;
    localparam int SUCC_WORD  = SYM_W + COUNT_BITS;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_PREDICT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PRED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [SYM_W-1:0] current_symbol;
        logic [SYM_W-1:0] next_symbol;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SYM_W-1:0]   predicted_symbol;
        logic [6:0]         context_total;
        logic [9:0]         transition_total;
        logic [OBS_W-1:0]   observation_total;
    } rsp_t;

endpackage

### src/msp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/msp_seq.sv
// Sequencer of the predictor: context search, successor scan, write-back and result register.
// Depends on msp_pkg and markov_successor_predictor_defines.svh; drives the two msp_ram instances.
`include "markov_successor_predictor_defines.svh"

module msp_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  msp_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output msp_pkg::rsp_t                   rsp,
    output logic                            ctx_we,
    output logic [msp_pkg::CTX_AW-1:0]      ctx_waddr,
    output logic [msp_pkg::CTX_WORD-1:0]    ctx_wdata,
    output logic [msp_pkg::CTX_AW-1:0]      ctx_raddr,
    input  logic [msp_pkg::CTX_WORD-1:0]    ctx_rdata,
    output logic                            succ_we,
    output logic [msp_pkg::SUCC_AW-1:0]     succ_waddr,
    output logic [msp_pkg::SUCC_WORD-1:0]   succ_wdata,
    output logic [msp_pkg::SUCC_AW-1:0]     succ_raddr,
    input  logic [msp_pkg::SUCC_WORD-1:0]   succ_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_CSCAN, S_SSCAN, S_FIN} state_t;
    typedef enum logic [2:0] {
        ACT_NEWCTX, ACT_INC, ACT_NEWSUCC, ACT_DROP, ACT_PRED_OK, ACT_PRED_NONE
    } act_t;

    state_t state_reg, state_next;
    act_t   act_reg, act_next;

    logic                             op_reg;
    logic [msp_pkg::SYM_W-1:0]        cur_reg, nxt_reg;
    logic [msp_pkg::CTX_W-1:0]        cidx_reg, cidx_next, pidx_reg;
    logic                             chk_reg, chk_next;
    logic [msp_pkg::CTX_AW-1:0]       ctx_reg, ctx_next;
    logic [msp_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [msp_pkg::FILL_W-1:0]       sidx_reg, sidx_next, spidx_reg;
    logic                             found_reg, found_next;
    logic [msp_pkg::SYM_W-1:0]        best_key_reg, best_key_next;
    logic [msp_pkg::COUNT_BITS-1:0]   best_cnt_reg, best_cnt_next;
    logic [msp_pkg::SAW-1:0]          hit_idx_reg, hit_idx_next;
    logic [msp_pkg::COUNT_BITS-1:0]   hit_cnt_reg, hit_cnt_next;

    logic [msp_pkg::CTX_W-1:0]        ctx_cnt_reg, ctx_cnt_next;
    logic [msp_pkg::TRANS_W-1:0]      trans_cnt_reg, trans_cnt_next;
    logic [msp_pkg::OBS_W-1:0]        obs_cnt_reg, obs_cnt_next;

    logic                             rsp_valid_reg, rsp_valid_next;
    msp_pkg::rsp_t                    rsp_reg, rsp_next;

    logic                             accept;
    logic                             slot_free;
    logic [msp_pkg::SYM_W-1:0]        ckey;
    logic [msp_pkg::FILL_W-1:0]       cfill;
    logic [msp_pkg::SYM_W-1:0]        skey;
    logic [msp_pkg::COUNT_BITS-1:0]   scnt;
    logic                             better;

    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign ckey      = ctx_rdata[msp_pkg::CTX_WORD-1 -: msp_pkg::SYM_W];
    assign cfill     = ctx_rdata[msp_pkg::FILL_W-1:0];
    assign skey      = succ_rdata[msp_pkg::SUCC_WORD-1 -: msp_pkg::SYM_W];
    assign scnt      = succ_rdata[msp_pkg::COUNT_BITS-1:0];

    // Tie on count goes to the smaller successor symbol.
    assign better = !found_reg || (scnt > best_cnt_reg) ||
                    ((scnt == best_cnt_reg) && (skey < best_key_reg));

    assign ctx_raddr  = cidx_reg[msp_pkg::CTX_AW-1:0];
    assign succ_raddr = {ctx_reg, sidx_reg[msp_pkg::SAW-1:0]};

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        cidx_next      = cidx_reg + 1'b1;
        chk_next       = 1'b1;
        ctx_next       = ctx_reg;
        fill_next      = fill_reg;
        sidx_next      = sidx_reg + 1'b1;
        found_next     = found_reg;
        best_key_next  = best_key_reg;
        best_cnt_next  = best_cnt_reg;
        hit_idx_next   = hit_idx_reg;
        hit_cnt_next   = hit_cnt_reg;
        ctx_cnt_next   = ctx_cnt_reg;
        trans_cnt_next = trans_cnt_reg;
        obs_cnt_next   = obs_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ctx_we         = 1'b0;
        ctx_waddr      = ctx_reg;
        ctx_wdata      = {cur_reg, fill_reg + 1'b1};
        succ_we        = 1'b0;
        succ_waddr     = {ctx_reg, hit_idx_reg};
        succ_wdata     = {nxt_reg, msp_pkg::COUNT_BITS'(1)};

        case (state_reg)
            S_IDLE:
            begin
                cidx_next = '0;
                chk_next  = 1'b0;
                if (accept)
                begin
                    state_next = S_CSCAN;
                end
            end

            // The read issued last cycle returns now; pidx_reg names its entry.
            S_CSCAN:
            begin
                sidx_next = '0;
                if (chk_reg)
                begin
                    if (pidx_reg >= ctx_cnt_reg)
                    begin
                        state_next = S_FIN;
                        if (op_reg == msp_pkg::OP_PREDICT)
                        begin
                            act_next = ACT_PRED_NONE;
                        end
                        else if (ctx_cnt_reg == msp_pkg::CTX_W'(msp_pkg::CTX_ENTRIES))
                        begin
                            act_next = ACT_DROP;
                        end
                        else
                        begin
                            act_next = ACT_NEWCTX;
                        end
                    end
                    else if (ckey == cur_reg)
                    begin
                        state_next = S_SSCAN;
                        ctx_next   = pidx_reg[msp_pkg::CTX_AW-1:0];
                        fill_next  = cfill;
                        found_next = 1'b0;
                        chk_next   = 1'b0;
                    end
                end
            end

            S_SSCAN:
            begin
                if (chk_reg)
                begin
                    if (spidx_reg >= fill_reg)
                    begin
                        state_next = S_FIN;
                        if (op_reg == msp_pkg::OP_PREDICT)
                        begin
                            act_next = found_reg ? ACT_PRED_OK : ACT_PRED_NONE;
                        end
                        else if (fill_reg == msp_pkg::FILL_W'(msp_pkg::SUCC_PER_CTX))
                        begin
                            act_next = ACT_DROP;
                        end
                        else
                        begin
                            act_next = ACT_NEWSUCC;
                        end
                    end
                    else if (op_reg == msp_pkg::OP_OBSERVE)
                    begin
                        if (skey == nxt_reg)
                        begin
                            state_next   = S_FIN;
                            act_next     = ACT_INC;
                            hit_idx_next = spidx_reg[msp_pkg::SAW-1:0];
                            hit_cnt_next = scnt;
                        end
                    end
                    else if (better)
                    begin
                        found_next    = 1'b1;
                        best_key_next = skey;
                        best_cnt_next = scnt;
                    end
                end
            end

            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next               = S_IDLE;
                    rsp_valid_next           = 1'b1;
                    rsp_next.status          = msp_pkg::ST_OK;
                    rsp_next.predicted_symbol = '0;
                    case (act_reg)
                        ACT_NEWCTX:
                        begin
                            ctx_we     = 1'b1;
                            ctx_waddr  = ctx_cnt_reg[msp_pkg::CTX_AW-1:0];
                            ctx_wdata  = {cur_reg, msp_pkg::FILL_W'(1)};
                            succ_we    = 1'b1;
                            succ_waddr = {ctx_cnt_reg[msp_pkg::CTX_AW-1:0],
                                          msp_pkg::SAW'(0)};
                            ctx_cnt_next   = ctx_cnt_reg + 1'b1;
                            trans_cnt_next = trans_cnt_reg + 1'b1;
                        end
                        ACT_INC:
                        begin
                            succ_we    = 1'b1;
                            succ_wdata = {nxt_reg, (hit_cnt_reg == '1) ? hit_cnt_reg
                                                                       : hit_cnt_reg + 1'b1};
                        end
                        ACT_NEWSUCC:
                        begin
                            ctx_we     = 1'b1;
                            succ_we    = 1'b1;
                            succ_waddr = {ctx_reg, fill_reg[msp_pkg::SAW-1:0]};
                            trans_cnt_next = trans_cnt_reg + 1'b1;
                        end
                        ACT_DROP:
                        begin
                            rsp_next.status = msp_pkg::ST_FULL;
                        end
                        ACT_PRED_OK:
                        begin
                            rsp_next.predicted_symbol = best_key_reg;
                        end
                        default:
                        begin
                            rsp_next.status = msp_pkg::ST_NO_PRED;
                        end
                    endcase
                    if ((act_reg == ACT_NEWCTX || act_reg == ACT_INC ||
                         act_reg == ACT_NEWSUCC) && obs_cnt_reg != '1)
                    begin
                        obs_cnt_next = obs_cnt_reg + 1'b1;
                    end
                    rsp_next.context_total     = 7'(ctx_cnt_next);
                    rsp_next.transition_total  = 10'(trans_cnt_next);
                    rsp_next.observation_total = obs_cnt_next;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            ctx_cnt_reg   <= '0;
            trans_cnt_reg <= '0;
            obs_cnt_reg   <= '0;
            chk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            ctx_cnt_reg   <= ctx_cnt_next;
            trans_cnt_reg <= trans_cnt_next;
            obs_cnt_reg   <= obs_cnt_next;
            chk_reg       <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            cur_reg <= req.current_symbol;
            nxt_reg <= req.next_symbol;
        end
        act_reg      <= act_next;
        cidx_reg     <= cidx_next;
        pidx_reg     <= cidx_reg;
        ctx_reg      <= ctx_next;
        fill_reg     <= fill_next;
        sidx_reg     <= sidx_next;
        spidx_reg    <= sidx_reg;
        found_reg    <= found_next;
        best_key_reg <= best_key_next;
        best_cnt_reg <= best_cnt_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        rsp_reg      <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `MSP_ASSERT(a_ctx_bound, ctx_cnt_reg <= msp_pkg::CTX_W'(msp_pkg::CTX_ENTRIES), "context count overflow")
    `MSP_ASSERT(a_trans_ge_ctx, msp_pkg::TRANS_W'(ctx_cnt_reg) <= trans_cnt_reg, "context without successor")
    `MSP_ASSERT(a_write_in_fin, (ctx_we || succ_we) |-> (state_reg == S_FIN && slot_free), "table write outside write-back")
    `MSP_ASSERT(a_ctx_step, (ctx_cnt_reg != $past(ctx_cnt_reg)) |-> (ctx_cnt_reg == $past(ctx_cnt_reg) + 1'b1), "context count jumped")

endmodule

### src/markov_successor_predictor.sv
// Top level of the first-order successor predictor: two table RAMs and the sequencer.
// Depends on msp_pkg, msp_ram and msp_seq.

// One item is handled at a time. Its context is looked up by a linear search of
// the context RAM, one entry per cycle over the stored contexts only, and a known
// context then has its row of successors scanned one entry per cycle from the
// successor RAM; a final write-back state writes the tables back and loads the
// result register once the result slot is free. A new item is taken while the
// previous result still waits to be collected. The tables need no clearing after
// reset: entries are allocated in order and tracked by the context and fill counts.
module markov_successor_predictor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  msp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output msp_pkg::rsp_t rsp
);

    logic                          ctx_we;
    logic [msp_pkg::CTX_AW-1:0]    ctx_waddr, ctx_raddr;
    logic [msp_pkg::CTX_WORD-1:0]  ctx_wdata, ctx_rdata;
    logic                          succ_we;
    logic [msp_pkg::SUCC_AW-1:0]   succ_waddr, succ_raddr;
    logic [msp_pkg::SUCC_WORD-1:0] succ_wdata, succ_rdata;

    msp_ram #(
        .WIDTH (msp_pkg::CTX_WORD),
        .DEPTH (msp_pkg::CTX_ENTRIES)
    ) u_ctx_ram (
        .clk   (clk),
        .we    (ctx_we),
        .waddr (ctx_waddr),
        .wdata (ctx_wdata),
        .raddr (ctx_raddr),
        .rdata (ctx_rdata)
    );

    msp_ram #(
        .WIDTH (msp_pkg::SUCC_WORD),
        .DEPTH (msp_pkg::SUCC_DEPTH)
    ) u_succ_ram (
        .clk   (clk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (succ_wdata),
        .raddr (succ_raddr),
        .rdata (succ_rdata)
    );

    msp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .ctx_we     (ctx_we),
        .ctx_waddr  (ctx_waddr),
        .ctx_wdata  (ctx_wdata),
        .ctx_raddr  (ctx_raddr),
        .ctx_rdata  (ctx_rdata),
        .succ_we    (succ_we),
        .succ_waddr (succ_waddr),
        .succ_wdata (succ_wdata),
        .succ_raddr (succ_raddr),
        .succ_rdata (succ_rdata)
    );

endmodule
